// File: hdl/vwos_pkg.sv
// vwos_pkg: shared sizes, codes and interface structs of the order splitter
// used by vwos_div and volume_weighted_order_splitter_core; no dependencies
package vwos_pkg;

  localparam int MAX_BUCKETS = 64;
  localparam int QTY_BITS    = 32;
  localparam int WEIGHT_BITS = 16;

  // fixed field widths
  localparam int BIDX_W    = 6;
  localparam int BCOUNT_W  = 7;
  localparam int SENT_W    = 7;
  localparam int FCNT_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;

  localparam int IDX_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
  localparam int SUM_W  = WEIGHT_BITS + CNT_W;
  localparam int PROD_W = WEIGHT_BITS + QTY_BITS;
  localparam int DCNT_W = $clog2(QTY_BITS + 1);

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_SLICE = 2'd2,
    FUNC_FILL  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_QTY    = 1'd0,
    REG_BUCKET_COUNT = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic              go;
    logic [PROD_W-1:0] dividend;
    logic [SUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QTY_BITS-1:0] quot;
  } div_rsp_t;

endpackage

// File: hdl/vwos_ram.sv
// vwos_ram: generic single write port, single read port ram
// read data is registered; no dependencies
module vwos_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/vwos_div.sv
// vwos_div: restoring divider, one quotient bit per cycle
// depends on vwos_pkg; quotient is known to fit in QTY_BITS
module vwos_div import vwos_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q;
  logic                done_q;
  logic [DCNT_W-1:0]   cnt_q;
  logic [SUM_W-1:0]    rem_q;
  logic [SUM_W-1:0]    dvsr_q;
  logic [QTY_BITS-1:0] lo_q;

  logic [SUM_W:0] trial;
  logic [SUM_W:0] diff;
  logic           ge;

  assign trial = {rem_q, lo_q[QTY_BITS-1]};
  assign diff  = trial - {1'b0, dvsr_q};
  assign ge    = trial >= {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(QTY_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // upper part of the dividend is already below the divisor
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      rem_q  <= {{(SUM_W-WEIGHT_BITS){1'b0}}, req_i.dividend[PROD_W-1:QTY_BITS]};
      lo_q   <= req_i.dividend[QTY_BITS-1:0];
      dvsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      lo_q  <= {lo_q[QTY_BITS-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = lo_q;

endmodule

// File: hdl/volume_weighted_order_splitter_core.sv
// volume_weighted_order_splitter_core: splits a parent quantity over buckets by weight
// depends on vwos_pkg, vwos_ram (weight and slice tables) and vwos_div
// load and fill go straight to output, a slice request reads the slice table first;
//   start sums weights, then the shared divider runs per bucket at one bit per cycle
// one item at a time; the next word is taken once the previous result is registered
// reset clears all counters and the weight valid bits, so the weight table reads zero;
//   no clearing pass; slice entries are valid only after a start writes them
module volume_weighted_order_splitter_core import vwos_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic [BIDX_W-1:0]    bucket_index_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  input  logic [QTY_BITS-1:0]  fill_qty_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [QTY_BITS-1:0]  child_qty_o,
  output logic                 order_complete_o,
  output logic [QTY_BITS-1:0]  qty_remaining_o,
  output logic [QTY_BITS-1:0]  qty_filled_o,
  output logic [SENT_W-1:0]    sent_count_o,
  output logic [FCNT_W-1:0]    fill_count_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SUM  = 8'b0000_0010,
    S_DRD  = 8'b0000_0100,
    S_DMUL = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_FIX  = 8'b0010_0000,
    S_SRD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [QTY_BITS-1:0] total_qty_q;
  logic [BCOUNT_W-1:0] bucket_count_q;

  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    ctr_q, ctr_d;
  logic                rd_pend_q, rd_pend_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [QTY_BITS-1:0] alloc_q, alloc_d;
  logic [QTY_BITS-1:0] first_q, first_d;
  logic [QTY_BITS-1:0] child_q, child_d;

  logic [CNT_W-1:0]    slices_q, slices_d;
  logic [CNT_W-1:0]    next_idx_q, next_idx_d;
  logic [QTY_BITS-1:0] remain_q, remain_d;
  logic [QTY_BITS-1:0] filled_q, filled_d;
  logic [SENT_W-1:0]   emitted_q, emitted_d;
  logic [FCNT_W-1:0]   fills_q, fills_d;

  logic [MAX_BUCKETS-1:0] weight_vld_q, weight_vld_d;
  logic                   wrd_vld_q;

  logic                   out_valid_q;
  logic                   out_load;

  // weight table ports
  logic                   w_we;
  logic [IDX_W-1:0]       w_waddr;
  logic [IDX_W-1:0]       w_raddr;
  logic [WEIGHT_BITS-1:0] w_rdata;
  logic [WEIGHT_BITS-1:0] weight_eff;

  // slice table ports
  logic                   s_we;
  logic [IDX_W-1:0]       s_waddr;
  logic [QTY_BITS-1:0]    s_wdata;
  logic [IDX_W-1:0]       s_raddr;
  logic [QTY_BITS-1:0]    s_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     div_go;

  logic                accept;
  logic [CNT_W-1:0]    n_cfg;
  logic [IDX_W-1:0]    load_addr;
  logic [QTY_BITS-1:0] actual;
  logic [QTY_BITS:0]   filled_sum;
  logic                issue;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);

  assign n_cfg      = (int'(bucket_count_q) > MAX_BUCKETS) ? CNT_W'(MAX_BUCKETS)
                                                            : CNT_W'(bucket_count_q);
  assign load_addr  = IDX_W'(bucket_index_i);
  assign actual     = (fill_qty_i < remain_q) ? fill_qty_i : remain_q;
  assign filled_sum = {1'b0, filled_q} + {1'b0, actual};
  assign weight_eff = wrd_vld_q ? w_rdata : '0;
  assign issue      = (ctr_q < n_q);

  assign s_raddr = next_idx_q[IDX_W-1:0];
  assign w_raddr = ctr_q[IDX_W-1:0];

  assign div_req.go       = div_go;
  assign div_req.dividend = {{QTY_BITS{1'b0}}, weight_eff} *
                            {{WEIGHT_BITS{1'b0}}, total_qty_q};
  assign div_req.divisor  = sum_q;

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    ctr_d        = ctr_q;
    rd_pend_d    = rd_pend_q;
    sum_d        = sum_q;
    alloc_d      = alloc_q;
    first_d      = first_q;
    child_d      = child_q;
    slices_d     = slices_q;
    next_idx_d   = next_idx_q;
    remain_d     = remain_q;
    filled_d     = filled_q;
    emitted_d    = emitted_q;
    fills_d      = fills_q;
    weight_vld_d = weight_vld_q;
    w_we         = 1'b0;
    w_waddr      = load_addr;
    s_we         = 1'b0;
    s_waddr      = '0;
    s_wdata      = total_qty_q;
    div_go       = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          child_d = '0;
          state_d = S_OUT;
          case (func_i)
            FUNC_LOAD: begin
              if (int'(bucket_index_i) < MAX_BUCKETS) begin
                w_we                    = 1'b1;
                weight_vld_d[load_addr] = 1'b1;
              end
            end
            FUNC_START: begin
              n_d        = n_cfg;
              ctr_d      = '0;
              sum_d      = '0;
              rd_pend_d  = 1'b0;
              next_idx_d = '0;
              remain_d   = total_qty_q;
              filled_d   = '0;
              emitted_d  = '0;
              fills_d    = '0;
              if (n_cfg == '0) begin
                // single slice holding the whole order
                s_we     = 1'b1;
                slices_d = CNT_W'(1);
              end else begin
                state_d = S_SUM;
              end
            end
            FUNC_SLICE: begin
              if (remain_q != '0 && next_idx_q < slices_q) begin
                state_d = S_SRD;
              end
            end
            FUNC_FILL: begin
              remain_d = remain_q - actual;
              filled_d = filled_sum[QTY_BITS] ? '1 : filled_sum[QTY_BITS-1:0];
              if (fills_q != '1) begin
                fills_d = fills_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        // one read issued per cycle, data lands in the cycle after
        if (issue) begin
          ctr_d = ctr_q + 1'b1;
        end
        rd_pend_d = issue;
        if (rd_pend_q) begin
          sum_d = sum_q + SUM_W'(weight_eff);
        end
        if (!issue && !rd_pend_q) begin
          ctr_d   = '0;
          alloc_d = '0;
          if (sum_q == '0) begin
            s_we     = 1'b1;
            slices_d = CNT_W'(1);
            state_d  = S_OUT;
          end else begin
            slices_d = n_q;
            state_d  = S_DRD;
          end
        end
      end
      S_DRD: begin
        state_d = S_DMUL;
      end
      S_DMUL: begin
        div_go  = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          s_we    = 1'b1;
          s_waddr = ctr_q[IDX_W-1:0];
          s_wdata = div_rsp.quot;
          alloc_d = alloc_q + div_rsp.quot;
          if (ctr_q == '0) begin
            first_d = div_rsp.quot;
          end
          ctr_d = ctr_q + 1'b1;
          if (ctr_q == n_q - 1'b1) begin
            state_d = S_FIX;
          end else begin
            state_d = S_DRD;
          end
        end
      end
      S_FIX: begin
        // rounding remainder goes to bucket 0
        s_we    = 1'b1;
        s_wdata = first_q + (total_qty_q - alloc_q);
        state_d = S_OUT;
      end
      S_SRD: begin
        child_d    = (s_rdata < remain_q) ? s_rdata : remain_q;
        next_idx_d = next_idx_q + 1'b1;
        if (emitted_q != '1) begin
          emitted_d = emitted_q + 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      total_qty_q    <= '0;
      bucket_count_q <= '0;
      n_q            <= '0;
      ctr_q          <= '0;
      rd_pend_q      <= 1'b0;
      slices_q       <= '0;
      next_idx_q     <= '0;
      remain_q       <= '0;
      filled_q       <= '0;
      emitted_q      <= '0;
      fills_q        <= '0;
      weight_vld_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      ctr_q        <= ctr_d;
      rd_pend_q    <= rd_pend_d;
      slices_q     <= slices_d;
      next_idx_q   <= next_idx_d;
      remain_q     <= remain_d;
      filled_q     <= filled_d;
      emitted_q    <= emitted_d;
      fills_q      <= fills_d;
      weight_vld_q <= weight_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TOTAL_QTY:    total_qty_q    <= QTY_BITS'(cfg_wdata_i);
          REG_BUCKET_COUNT: bucket_count_q <= BCOUNT_W'(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    alloc_q   <= alloc_d;
    first_q   <= first_d;
    child_q   <= child_d;
    wrd_vld_q <= weight_vld_q[w_raddr];
    if (out_load) begin
      child_qty_o      <= child_q;
      order_complete_o <= (remain_q == '0);
      qty_remaining_o  <= remain_q;
      qty_filled_o     <= filled_q;
      sent_count_o     <= emitted_q;
      fill_count_o     <= fills_q;
    end
  end

  assign out_valid_o = out_valid_q;

  vwos_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_BUCKETS)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (weight_i),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  vwos_ram #(
    .WIDTH (QTY_BITS),
    .DEPTH (MAX_BUCKETS)
  ) u_slice_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  vwos_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // an accepted word always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted word did not start work");

  // divider answers only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider result outside of divide step");

  // the slice pointer never runs past the slices in use
  a_next_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_idx_q <= slices_q)
    else $error("slice pointer beyond slices in use");

  // every emitted slice advances the pointer by one
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SENT_W'(next_idx_q) == emitted_q)
    else $error("emitted count out of step with slice pointer");

  // a result is only loaded when the output slot is free
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || !out_stall_i)
    else $error("result overwritten while stalled");

endmodule

// File: tb/sv/volume_weighted_order_splitter_core_tb.sv
// volume_weighted_order_splitter_core_tb: self-checking bench for the order splitter core
// predicts every result word from its own model of weights, slices and fill counters
// depends on vwos_pkg and volume_weighted_order_splitter_core
module volume_weighted_order_splitter_core_tb;
  import vwos_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [31:0] child_qty;
    logic        complete;
    logic [31:0] remaining;
    logic [31:0] filled;
    logic [6:0]  sent;
    logic [31:0] fills;
  } slice_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DAT_W-1:0]   cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [1:0]             func_i;
  logic [BIDX_W-1:0]      bucket_index_i;
  logic [WEIGHT_BITS-1:0] weight_i;
  logic [QTY_BITS-1:0]    fill_qty_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [QTY_BITS-1:0]    child_qty_o;
  logic                   order_complete_o;
  logic [QTY_BITS-1:0]    qty_remaining_o;
  logic [QTY_BITS-1:0]    qty_filled_o;
  logic [SENT_W-1:0]      sent_count_o;
  logic [FCNT_W-1:0]      fill_count_o;

  // predicted block state
  logic [15:0] weight_tab [64];
  logic [31:0] slice_tab [64];
  logic [6:0]  slices_used;
  logic [6:0]  slice_ptr;
  logic [31:0] qty_left;
  logic [31:0] qty_done;
  logic [6:0]  slices_sent;
  logic [31:0] fill_reps;
  logic [31:0] cfg_total_qty;
  logic [6:0]  cfg_buckets;

  slice_result_t slice_results_q [$];
  int mismatches;
  int item_count;
  int send_idle_pct;
  int recv_idle_pct;
  int cycles;

  volume_weighted_order_splitter_core dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("volume_weighted_order_splitter_core_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  function automatic slice_result_t split_step(func_e f, logic [5:0] idx, logic [15:0] w,
                                               logic [31:0] fq);
    slice_result_t r;
    logic [31:0] take;
    logic [63:0] sum;
    logic [63:0] alloc;
    logic [63:0] part;
    int n;
    int i;
    take = '0;
    case (f)
      FUNC_LOAD: weight_tab[idx] = w;
      FUNC_START: begin
        n = (cfg_buckets > 7'd64) ? 64 : int'(cfg_buckets);
        sum = '0;
        for (i = 0; i < n; i++) sum += 64'(weight_tab[i]);
        if (n == 0 || sum == 0) begin
          slice_tab[0] = cfg_total_qty;
          slices_used = 7'd1;
        end else begin
          alloc = '0;
          for (i = 0; i < n; i++) begin
            part = (64'(weight_tab[i]) * 64'(cfg_total_qty)) / sum;
            slice_tab[i] = part[31:0];
            alloc += part;
          end
          // rounding leftover goes to the first bucket
          if (alloc < 64'(cfg_total_qty)) slice_tab[0] = slice_tab[0] + (cfg_total_qty - alloc[31:0]);
          slices_used = 7'(n);
        end
        slice_ptr = '0;
        qty_left = cfg_total_qty;
        qty_done = '0;
        slices_sent = '0;
        fill_reps = '0;
      end
      FUNC_SLICE: begin
        if (qty_left != 0 && slice_ptr < slices_used) begin
          take = slice_tab[slice_ptr[5:0]];
          if (take > qty_left) take = qty_left;
          slice_ptr++;
          if (slices_sent < 7'd127) slices_sent++;
        end
      end
      default: begin
        take = (fq < qty_left) ? fq : qty_left;
        qty_left -= take;
        if (33'(qty_done) + 33'(take) > 33'h0_FFFF_FFFF) qty_done = '1;
        else qty_done = qty_done + take;
        if (fill_reps != '1) fill_reps++;
        take = '0;
      end
    endcase
    r.child_qty = take;
    r.complete  = (qty_left == 0);
    r.remaining = qty_left;
    r.filled    = qty_done;
    r.sent      = slices_sent;
    r.fills     = fill_reps;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    slice_result_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (slice_results_q.size() == 0) begin
        $display("%0t: result word with none expected, child_qty %0h", $time, child_qty_o);
        mismatches++;
      end else begin
        exp = slice_results_q.pop_front();
        check_field("child_qty", exp.child_qty, child_qty_o);
        check_field("order_complete", 32'(exp.complete), 32'(order_complete_o));
        check_field("qty_remaining", exp.remaining, qty_remaining_o);
        check_field("qty_filled", exp.filled, qty_filled_o);
        check_field("sent_count", 32'(exp.sent), 32'(sent_count_o));
        check_field("fill_count", exp.fills, fill_count_o);
      end
    end
  end

  task automatic send_word(func_e f, logic [5:0] idx = '0, logic [15:0] w = '0,
                           logic [31:0] fq = '0);
    slice_result_t exp_word;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= f;
    bucket_index_i <= idx;
    weight_i       <= w;
    fill_qty_i     <= fq;
    do @(posedge clk_i); while (in_stall_o);
    exp_word = split_step(f, idx, w, fq);
    slice_results_q.insert(slice_results_q.size(), exp_word);
    item_count++;
  endtask

  // lowers the input valid and waits until every result word is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (slice_results_q.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data, bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_TOTAL_QTY) cfg_total_qty = data;
    else cfg_buckets = data[6:0];
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic test_before_start();
    send_word(FUNC_SLICE);
    send_word(FUNC_FILL, 6'd0, 16'd0, 32'hFFFF_FFFF);
    send_word(FUNC_FILL, 6'd0, 16'd0, 32'd0);
  endtask

  task automatic test_full_scale_split();
    send_word(FUNC_LOAD, 6'd0, 16'hFFFF);
    send_word(FUNC_LOAD, 6'd1, 16'd1);
    send_word(FUNC_LOAD, 6'd2, 16'h8000);
    send_word(FUNC_LOAD, 6'd61, 16'hAAAA);
    send_word(FUNC_LOAD, 6'd62, 16'h5555);
    send_word(FUNC_LOAD, 6'd63, 16'hFFFF);
    drain_results();
    // bucket count above the table size saturates
    write_reg(REG_TOTAL_QTY, 32'hFFFF_FFFF, 1'b0);
    write_reg(REG_BUCKET_COUNT, 32'd127, 1'b1);
    send_word(FUNC_START);
    repeat (3) send_word(FUNC_SLICE);
    send_word(FUNC_FILL, 6'd0, 16'd0, 32'hFFFF_FFFF);
    send_word(FUNC_SLICE);
    send_word(FUNC_FILL, 6'd0, 16'd0, 32'd0);
  endtask

  task automatic test_single_slice();
    drain_results();
    write_reg(REG_TOTAL_QTY, 32'd1000, 1'b0);
    write_reg(REG_BUCKET_COUNT, 32'd0, 1'b1);
    send_word(FUNC_START);
    // slice above what is left gets clamped, then slices are used up
    send_word(FUNC_FILL, 6'd0, 16'd0, 32'd400);
    send_word(FUNC_SLICE);
    send_word(FUNC_SLICE);
    drain_results();
    write_reg(REG_BUCKET_COUNT, 32'd1, 1'b1);
    send_word(FUNC_LOAD, 6'd0, 16'd0);
    send_word(FUNC_START);
    send_word(FUNC_SLICE);
    drain_results();
    write_reg(REG_TOTAL_QTY, 32'd0, 1'b1);
    send_word(FUNC_START);
    send_word(FUNC_SLICE);
  endtask

  task automatic test_random_orders(int send_pct, int recv_pct, int n_items);
    int stop;
    int bc;
    int used;
    int pick;
    logic [31:0] tot;
    logic [31:0] fq;
    logic [15:0] w;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop = item_count + n_items;
    while (item_count < stop) begin
      drain_results();
      pick = $urandom_range(99);
      if (pick < 5) bc = $urandom_range(64, 127);
      else if (pick < 12) bc = 0;
      else bc = $urandom_range(1, 8);
      used = (bc > 64) ? 64 : bc;
      case ($urandom_range(9))
        0: tot = 32'd0;
        1: tot = 32'hFFFF_FFFF;
        2: tot = $urandom();
        3, 4: tot = $urandom_range(1, 16);
        default: tot = $urandom_range(1, 100000);
      endcase
      write_reg(REG_TOTAL_QTY, tot, 1'b0);
      write_reg(REG_BUCKET_COUNT,
                {($urandom_range(1) ? 25'($urandom()) : 25'd0), 7'(bc)}, 1'b1);
      repeat ($urandom_range(0, used + 1)) begin
        case ($urandom_range(5))
          0: w = 16'd0;
          1: w = 16'hFFFF;
          2: w = 16'($urandom_range(1, 10));
          default: w = 16'($urandom());
        endcase
        send_word(FUNC_LOAD, (used > 0 && $urandom_range(3) != 0) ?
                  6'($urandom_range(used - 1)) : 6'($urandom_range(63)), w, $urandom());
      end
      send_word(FUNC_START, 6'($urandom()), 16'($urandom()), $urandom());
      repeat ($urandom_range(4, 16)) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_word(FUNC_SLICE, 6'($urandom()), 16'($urandom()), $urandom());
        end else if (pick < 80) begin
          case ($urandom_range(3))
            0: fq = $urandom_range(qty_left);
            1: fq = qty_left / $urandom_range(1, 4);
            2: fq = $urandom();
            default: fq = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
          endcase
          send_word(FUNC_FILL, 6'($urandom()), 16'($urandom()), fq);
        end else if (pick < 90) begin
          send_word(FUNC_LOAD, 6'($urandom()), 16'($urandom()), $urandom());
        end else if (pick < 95) begin
          send_word(FUNC_START, 6'($urandom()), 16'($urandom()), $urandom());
        end else begin
          send_word(func_e'($urandom_range(3)), 6'($urandom()), 16'($urandom()),
                    $urandom());
        end
      end
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= REG_TOTAL_QTY;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    func_i         <= FUNC_LOAD;
    bucket_index_i <= '0;
    weight_i       <= '0;
    fill_qty_i     <= '0;
    out_stall_i    <= 1'b0;
    foreach (weight_tab[i]) weight_tab[i] = '0;
    foreach (slice_tab[i]) slice_tab[i] = '0;
    slices_used   = '0;
    slice_ptr     = '0;
    qty_left      = '0;
    qty_done      = '0;
    slices_sent   = '0;
    fill_reps     = '0;
    cfg_total_qty = '0;
    cfg_buckets   = '0;
    mismatches    = 0;
    item_count    = 0;
    cycles        = 0;
    send_idle_pct = 21;
    recv_idle_pct = 51;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_start();
    test_full_scale_split();
    test_single_slice();
    test_random_orders(21, 51, 300);
    test_random_orders(51, 21, 300);
    test_random_orders(0, 0, 300);

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("volume_weighted_order_splitter_core_tb: clean");
    end else begin
      $display("volume_weighted_order_splitter_core_tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/vwos_pkg.sv
hdl/vwos_ram.sv
hdl/vwos_div.sv
hdl/volume_weighted_order_splitter_core.sv
tb/sv/volume_weighted_order_splitter_core_tb.sv
